// File: rtl/pgc_pkg.sv
// Package with widths, constants and elaboration-time tables for the gamma block.
package pgc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LW = FRAC_BITS + 3;   // log2 value, integer part up to 7
    localparam int GW = FRAC_BITS + 2;   // gamma, up to 2.0
    localparam int RW = FRAC_BITS + 2;   // root constants, up to 2.0
    localparam int EW = FRAC_BITS + 1;   // partial power, below 2.0
    localparam int NW = FRAC_BITS + 5;   // scaled log product
    localparam int KW = 5;
    localparam int DIVW = FRAC_BITS + 8;
    localparam int CNTW = $clog2(DIVW + 1);
    localparam int NST = FRAC_BITS + 4;

    localparam int BRIGHT_RST = 256;
    localparam logic [GW-1:0] GAMMA_RST = GW'((128 << FRAC_BITS) / (BRIGHT_RST + 64));

    typedef logic [LW-1:0] log_tab_t [256];
    typedef logic [RW-1:0] r_tab_t [FRAC_BITS+1];

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] t;
        res = 64'd0;
        for (int i = 31; i >= 0; i--) begin
            t = res | (64'd1 << i);
            if (t * t <= v) begin
                res = t;
            end
        end
        return res;
    endfunction

    function automatic log_tab_t gen_log();
        log_tab_t tab;
        logic [63:0] m;
        logic [63:0] frac;
        int e;
        for (int x = 0; x < 256; x++) begin
            if (x == 0) begin
                tab[x] = '0;
            end else begin
                e = 7;
                while (((x >> e) & 1) == 0) e--;
                m = (64'(x) << FRAC_BITS) >> e;
                frac = 64'd0;
                for (int i = FRAC_BITS - 1; i >= 0; i--) begin
                    m = (m * m) >> FRAC_BITS;
                    if (m >= (64'd2 << FRAC_BITS)) begin
                        m = m >> 1;
                        frac = frac | (64'd1 << i);
                    end
                end
                tab[x] = LW'((64'(e) << FRAC_BITS) | frac);
            end
        end
        return tab;
    endfunction

    function automatic r_tab_t gen_roots();
        r_tab_t tab;
        logic [63:0] r;
        r = 64'd2 << FRAC_BITS;
        tab[0] = RW'(r);
        for (int i = 1; i <= FRAC_BITS; i++) begin
            r = isqrt(r << FRAC_BITS);
            tab[i] = RW'(r);
        end
        return tab;
    endfunction

    localparam log_tab_t LOG_TAB = gen_log();
    localparam r_tab_t R_TAB = gen_roots();

endpackage

// File: rtl/pixel_gamma_correction.sv
// Pipelined power-law gamma correction of RGBA pixels with an APB brightness register.
// Stages: log difference, gamma scale, split, exp2 (one root multiply each), final scaling.
// Throughput: one pixel per cycle; the whole pipeline stalls while the output word waits.
// After a brightness write, input is held off while gamma is divided.
// Reset (synchronous, active low) sets brightness to 1.0, gamma to 0.4 and empties the pipe.
module pixel_gamma_correction (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pgc_pkg::*;

    logic [11:0]     bright_reg;
    logic [GW-1:0]   gamma_reg;
    logic            busy_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DIVW-1:0] quo_reg;
    logic [13:0]     rem_reg;
    logic [13:0]     rem_shift;
    logic [13:0]     divisor;
    logic            wr_en;

    assign pready = 1'b1;
    assign prdata = {20'd0, bright_reg};
    assign wr_en  = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign divisor = 14'(bright_reg) + 14'd64;
    assign rem_shift = {rem_reg[12:0], quo_reg[DIVW-1]};

    // Brightness register and restoring divider, one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= 12'(BRIGHT_RST);
            gamma_reg  <= GAMMA_RST;
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            quo_reg    <= DIVW'(GAMMA_RST);
            rem_reg    <= '0;
        end else if (wr_en) begin
            bright_reg <= pwdata[11:0];
            busy_reg   <= 1'b1;
            cnt_reg    <= CNTW'(DIVW);
            quo_reg    <= DIVW'(128) << FRAC_BITS;
            rem_reg    <= '0;
        end else if (busy_reg) begin
            if (rem_shift >= divisor) begin
                rem_reg <= rem_shift - divisor;
                quo_reg <= {quo_reg[DIVW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[DIVW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                busy_reg <= 1'b0;
            end
        end else begin
            gamma_reg <= quo_reg[GW-1:0];
        end
    end

    logic adv;
    logic [NST-1:0] vld_reg;
    logic [7:0]     alpha_reg [NST];
    logic [7:0]     res [3];

    assign adv      = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv && !busy_reg;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {res[2], res[1], res[0], alpha_reg[NST-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid && s_tready};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            alpha_reg[0] <= s_tdata[7:0];
            for (int s = 1; s < NST; s++) begin
                alpha_reg[s] <= alpha_reg[s-1];
            end
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        logic [7:0]          c_in;
        logic [LW-1:0]       lc;
        logic [LW-1:0]       d_reg;
        logic                zero_reg [NST-1];
        logic [NW-1:0]       n_reg;
        logic [GW+LW-1:0]    prod;
        logic [KW-1:0]       k_reg [2:NST-2];
        logic                fz_reg [2:NST-2];
        logic [FRAC_BITS-1:0] g_reg [2:NST-2];
        logic [EW-1:0]       e_reg [2:NST-2];
        logic [FRAC_BITS-1:0] f_val;
        logic [EW-1:0]       p_val;
        logic [FRAC_BITS+8:0] scaled;
        logic [8:0]          out9;
        logic [7:0]          out_reg;

        assign c_in  = s_tdata[8*ch+15 -: 8];
        assign lc    = LOG_TAB[c_in];
        assign prod  = (GW+LW)'(gamma_reg) * (GW+LW)'(d_reg);
        assign f_val = n_reg[FRAC_BITS-1:0];

        always_comb begin
            if (fz_reg[NST-2]) begin
                p_val = (EW'(1) << FRAC_BITS) >> k_reg[NST-2];
            end else begin
                p_val = e_reg[NST-2] >> (6'(k_reg[NST-2]) + 6'd1);
            end
            scaled = ((FRAC_BITS+9)'(p_val) << 8) - (FRAC_BITS+9)'(p_val);
            out9   = scaled[FRAC_BITS+8:FRAC_BITS];
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                // Stage 1: log difference against full scale.
                d_reg       <= (LOG_TAB[255] > lc) ? (LOG_TAB[255] - lc) : '0;
                zero_reg[0] <= (c_in == 8'd0);
                // Stage 2: scale by gamma.
                n_reg       <= prod[FRAC_BITS+NW-1:FRAC_BITS];
                zero_reg[1] <= zero_reg[0];
                // Stage 3: split into integer shift and fraction.
                k_reg[2]    <= n_reg[FRAC_BITS+KW-1:FRAC_BITS];
                fz_reg[2]   <= (f_val == '0);
                g_reg[2]    <= FRAC_BITS'((FRAC_BITS+1)'(1) << FRAC_BITS) - f_val;
                e_reg[2]    <= EW'(1) << FRAC_BITS;
                zero_reg[2] <= zero_reg[1];
                // Exp stages: one root constant per fraction bit, top bit first.
                for (int i = 1; i <= FRAC_BITS; i++) begin
                    k_reg[i+2]    <= k_reg[i+1];
                    fz_reg[i+2]   <= fz_reg[i+1];
                    g_reg[i+2]    <= g_reg[i+1];
                    zero_reg[i+2] <= zero_reg[i+1];
                    if (g_reg[i+1][FRAC_BITS-i]) begin
                        e_reg[i+2] <= EW'(((EW+RW)'(e_reg[i+1]) * (EW+RW)'(R_TAB[i]))
                                          >> FRAC_BITS);
                    end else begin
                        e_reg[i+2] <= e_reg[i+1];
                    end
                end
                // Final stage: scale to 0..255 and saturate; a zero input gives zero.
                if (zero_reg[NST-2]) begin
                    out_reg <= 8'd0;
                end else if (out9[8]) begin
                    out_reg <= 8'd255;
                end else begin
                    out_reg <= out9[7:0];
                end
            end
        end

        assign res[ch] = out_reg;
    end

endmodule
